[rtl/plist_pkg.sv]
// Package for the positional insert/delete list.
// Holds sizes, field widths, request and status codes, and the controller/datapath
// command types. It has no dependencies.
package plist_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KIND_W   = 2;
    localparam int POS_W    = 8;
    localparam int ELEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    // Position and count are compared at a common width.
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DN,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_POS,
        PTR_TOP,
        PTR_POS_UP,
        PTR_DEC,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ELEM_POS,
        WR_SHIFT_UP,
        WR_SHIFT_DN
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } cnt_op_t;

    typedef struct packed {
        logic    take_req;
        logic    take_status;
        ptr_op_t ptr_op;
        logic    rd_en;
        wr_op_t  wr_op;
        cnt_op_t cnt_op;
        logic    load_result;
    } dp_cmd_t;

    typedef struct packed {
        kind_t   kind;
        status_t chk;
        logic    pos_eq_cnt;
        logic    pos_eq_last;
        logic    ptr_at_pos;
        logic    ptr_at_last;
        logic    out_free;
    } dp_stat_t;

endpackage

[rtl/plist_if.sv]
// Handshake interfaces for the request and result words of the list block.
// Depends on plist_pkg for the field widths.
interface plist_req_if import plist_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [ELEM_W-1:0] element;

    modport source (output valid, output kind, output position, output element, input ready);
    modport sink   (input valid, input kind, input position, input element, output ready);
endinterface

interface plist_rsp_if import plist_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic signed [ELEM_W-1:0] read_value;

    modport source (output valid, output status, output count, output read_value, input ready);
    modport sink   (input valid, input status, input count, input read_value, output ready);
endinterface

[rtl/plist_dp.sv]
// Datapath of the list: request registers, entry memory, count, shift pointer
// and result register. Depends on plist_pkg; driven by plist_ctrl.
module plist_dp import plist_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic [KIND_W-1:0]        req_kind,
    input  logic [POS_W-1:0]         req_position,
    input  logic signed [ELEM_W-1:0] req_element,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STATUS_W-1:0]      out_status,
    output logic [COUNT_W-1:0]       out_count,
    output logic signed [ELEM_W-1:0] out_read_value
);

    logic [ELEM_W-1:0] mem [CAPACITY];

    kind_t                 kind_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [ELEM_W-1:0]     elem_reg;
    status_t               stat_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     ptr_reg, ptr_next;
    logic [ELEM_W-1:0]     rd_data_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [ELEM_W-1:0]     out_value_reg;

    logic [CMP_W-1:0]      pos_cmp, cnt_cmp;
    logic [ADDR_W-1:0]     pos_addr, last_addr;
    status_t               chk;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ELEM_W-1:0]     wr_data;

    assign pos_cmp   = CMP_W'(pos_reg);
    assign cnt_cmp   = CMP_W'(count_reg);
    assign pos_addr  = ADDR_W'(pos_reg);
    assign last_addr = ADDR_W'(count_reg - CNT_W'(1));

    // Outcome of the held request against the current count.
    always_comb
    begin
        chk = ST_OK;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (count_reg >= CNT_W'(CAPACITY))
                    chk = ST_FULL;
                else if (pos_cmp > cnt_cmp)
                    chk = ST_BADPOS;
            end
            KIND_DELETE, KIND_READ:
            begin
                if (count_reg == '0)
                    chk = ST_EMPTY;
                else if (pos_cmp >= cnt_cmp)
                    chk = ST_BADPOS;
            end
            default: chk = ST_OK;
        endcase
    end

    always_comb
    begin
        stat.kind        = kind_reg;
        stat.chk         = chk;
        stat.pos_eq_cnt  = (pos_cmp == cnt_cmp);
        stat.pos_eq_last = (pos_cmp + CMP_W'(1) == cnt_cmp);
        stat.ptr_at_pos  = (ptr_reg == pos_addr);
        stat.ptr_at_last = (ptr_reg == last_addr);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        case (cmd.ptr_op)
            PTR_POS:    ptr_next = pos_addr;
            PTR_TOP:    ptr_next = last_addr;
            PTR_POS_UP: ptr_next = pos_addr + ADDR_W'(1);
            PTR_DEC:    ptr_next = ptr_reg - ADDR_W'(1);
            PTR_INC:    ptr_next = ptr_reg + ADDR_W'(1);
            default:    ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC:   count_next = count_reg + CNT_W'(1);
            CNT_DEC:   count_next = count_reg - CNT_W'(1);
            CNT_CLEAR: count_next = '0;
            default:   count_next = count_reg;
        endcase
    end

    // The shifting writes move the word just read one slot up or down.
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = pos_addr;
        wr_data = elem_reg;
        case (cmd.wr_op)
            WR_ELEM_POS:
            begin
                wr_addr = pos_addr;
                wr_data = elem_reg;
            end
            WR_SHIFT_UP:
            begin
                wr_addr = ptr_reg + ADDR_W'(1);
                wr_data = rd_data_reg;
            end
            WR_SHIFT_DN:
            begin
                wr_addr = ptr_reg - ADDR_W'(1);
                wr_data = rd_data_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[ptr_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            kind_reg <= kind_t'(req_kind);
            pos_reg  <= req_position;
            elem_reg <= req_element;
        end
        if (cmd.take_status)
            stat_reg <= chk;
        ptr_reg <= ptr_next;
        if (cmd.load_result)
        begin
            out_status_reg <= stat_reg;
            out_count_reg  <= COUNT_W'(count_reg);
            out_value_reg  <= (stat_reg == ST_OK && kind_reg == KIND_READ) ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load_result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_count      = out_count_reg;
    assign out_read_value = out_value_reg;

endmodule

[rtl/plist_ctrl.sv]
// Controller state machine of the list: sequences one request through decision,
// entry shifting and result hand-off. Depends on plist_pkg; drives plist_dp.
module plist_ctrl import plist_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECIDE;
            S_DECIDE:
            begin
                state_next = S_FINISH;
                if (stat.chk == ST_OK)
                begin
                    if (stat.kind == KIND_INSERT && !stat.pos_eq_cnt)
                        state_next = S_SHIFT_UP;
                    else if (stat.kind == KIND_DELETE && !stat.pos_eq_last)
                        state_next = S_SHIFT_DN;
                end
            end
            S_SHIFT_UP:
                if (stat.ptr_at_pos)
                    state_next = S_PLACE;
            S_PLACE:
                state_next = S_FINISH;
            S_SHIFT_DN:
                if (stat.ptr_at_last)
                    state_next = S_FINISH;
            S_FINISH:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd.take_req    = 1'b0;
        cmd.take_status = 1'b0;
        cmd.ptr_op      = PTR_HOLD;
        cmd.rd_en       = 1'b0;
        cmd.wr_op       = WR_NONE;
        cmd.cnt_op      = CNT_HOLD;
        cmd.load_result = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.take_req = in_valid;
            end
            S_DECIDE:
            begin
                cmd.take_status = 1'b1;
                if (stat.chk == ST_OK)
                begin
                    case (stat.kind)
                        KIND_INSERT:
                        begin
                            if (stat.pos_eq_cnt)
                            begin
                                cmd.wr_op  = WR_ELEM_POS;
                                cmd.cnt_op = CNT_INC;
                            end
                            else
                            begin
                                cmd.ptr_op = PTR_TOP;
                                cmd.rd_en  = 1'b1;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (stat.pos_eq_last)
                                cmd.cnt_op = CNT_DEC;
                            else
                            begin
                                cmd.ptr_op = PTR_POS_UP;
                                cmd.rd_en  = 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            cmd.ptr_op = PTR_POS;
                            cmd.rd_en  = 1'b1;
                        end
                        default:
                            cmd.cnt_op = CNT_CLEAR;
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                cmd.wr_op = WR_SHIFT_UP;
                if (!stat.ptr_at_pos)
                begin
                    cmd.ptr_op = PTR_DEC;
                    cmd.rd_en  = 1'b1;
                end
            end
            S_PLACE:
            begin
                cmd.wr_op  = WR_ELEM_POS;
                cmd.cnt_op = CNT_INC;
            end
            S_SHIFT_DN:
            begin
                cmd.wr_op = WR_SHIFT_DN;
                if (stat.ptr_at_last)
                    cmd.cnt_op = CNT_DEC;
                else
                begin
                    cmd.ptr_op = PTR_INC;
                    cmd.rd_en  = 1'b1;
                end
            end
            S_FINISH:
                cmd.load_result = stat.out_free;
            default:
                in_ready = 1'b0;
        endcase
    end

endmodule

[rtl/positional_insert_delete_list_top.sv]
// Top level of the positional insert/delete list.
// Depends on plist_pkg, plist_if, plist_ctrl and plist_dp.
//
//  Channel  Dir  Fields                         Word
//  req      in   kind, position, element        one request
//  rsp      out  status, count, read_value      one result per request
//
// Read, clear, an append at the end, a delete of the last entry and a rejected request
// go from the decide state straight to the final state, which loads the result register,
// and the next request is taken once the block is back in idle. With one read and one
// write port, an insert moves one entry per shift step and then places the new word, and
// a delete moves one entry per shift step. Reset clears the state machine,
// the count and the result valid; a stalled result holds the block in its final state.
module positional_insert_delete_list_top import plist_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    plist_req_if.sink req,
    plist_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller only sequences; every stored data value lives in the datapath.
    plist_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the entry memory, the count and the result register.
    plist_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_kind       (req.kind),
        .req_position   (req.position),
        .req_element    (req.element),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_status     (rsp.status),
        .out_count      (rsp.count),
        .out_read_value (rsp.read_value)
    );

endmodule
